// ===== rtl/core/asc_pkg.sv =====
// shared constants, register indexes and control structs of the advection stencil
package asc_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 4096;
  localparam int COL_W       = 10;
  localparam int ROW_W       = 12;
  localparam int GW_W        = 11;
  localparam int GH_W        = 13;
  localparam int DT_W        = 16;
  localparam int FADDR_W     = COL_W + 1;
  localparam int IN_W        = 48;
  localparam int OUT_W       = 40;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [GW_W-1:0] GW_MIN   = GW_W'(3);
  localparam logic [GW_W-1:0] GW_MAX   = GW_W'(MAX_WIDTH);
  localparam logic [GH_W-1:0] GH_MIN   = GH_W'(3);
  localparam logic [GH_W-1:0] GH_MAX   = GH_W'(MAX_HEIGHT);
  localparam logic [GW_W-1:0] GW_RESET = GW_W'(256);
  localparam logic [GH_W-1:0] GH_RESET = GH_W'(256);
  localparam logic [DT_W-1:0] DT_RESET = DT_W'(66);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_WIDTH  = 2'd0,
    REG_GRID_HEIGHT = 2'd1,
    REG_TIME_STEP   = 2'd2
  } reg_idx_t;

  // effective geometry and time step seen by the datapath
  typedef struct packed {
    logic [GW_W-1:0] width;
    logic [GH_W-1:0] height;
    logic [DT_W-1:0] dt;
  } geom_t;

  typedef struct packed {
    logic take;
    logic rd_left;
    logic rd_mid;
    logic rd_right;
    logic rd_up;
    logic cap_left;
    logic cap_mid;
    logic cap_right;
    logic mul_x;
    logic mul_y;
    logic sum;
    logic scale;
    logic load_out;
    logic write_store;
  } cmd_t;

  typedef struct packed {
    logic interior;
    logic out_free;
  } stat_t;

endpackage

// ===== rtl/core/asc_ctrl.sv =====
// sequencer that steps one grid point through reads, products and result load, or a boundary point to the store write
module asc_ctrl import asc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  output logic  in_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [10:0] {
    S_IDLE     = 11'b00000000001,
    S_WRITE    = 11'b00000000010,
    S_RD_LEFT  = 11'b00000000100,
    S_RD_MID   = 11'b00000001000,
    S_RD_RIGHT = 11'b00000010000,
    S_RD_UP    = 11'b00000100000,
    S_MUL_X    = 11'b00001000000,
    S_MUL_Y    = 11'b00010000000,
    S_SUM      = 11'b00100000000,
    S_SCALE    = 11'b01000000000,
    S_OUTPUT   = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.take  = 1'b1;
          state_nxt = stat.interior ? S_RD_LEFT : S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.write_store = 1'b1;
        state_nxt       = S_IDLE;
      end
      S_RD_LEFT: begin
        cmd.rd_left = 1'b1;
        state_nxt   = S_RD_MID;
      end
      S_RD_MID: begin
        cmd.rd_mid   = 1'b1;
        cmd.cap_left = 1'b1;
        state_nxt    = S_RD_RIGHT;
      end
      S_RD_RIGHT: begin
        cmd.rd_right = 1'b1;
        cmd.cap_mid  = 1'b1;
        state_nxt    = S_RD_UP;
      end
      S_RD_UP: begin
        cmd.rd_up     = 1'b1;
        cmd.cap_right = 1'b1;
        state_nxt     = S_MUL_X;
      end
      S_MUL_X: begin
        cmd.mul_x = 1'b1;
        state_nxt = S_MUL_Y;
      end
      S_MUL_Y: begin
        cmd.mul_y = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = S_OUTPUT;
      end
      S_OUTPUT: begin
        // hold here while the previous word still sits in the output register
        if (stat.out_free) begin
          cmd.load_out    = 1'b1;
          cmd.write_store = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/core/asc_dp.sv =====
// line stores, position counters, stencil arithmetic and output register
module asc_dp import asc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  geom_t            geom,
  input  logic             restart,
  input  cmd_t             cmd,
  output stat_t            stat,
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,
  output logic             out_tlast
);

  // line stores: field has one bank per row parity, velocity holds {v, u}
  logic [SAMPLE_BITS-1:0]   field_mem [2*MAX_WIDTH];
  logic [2*SAMPLE_BITS-1:0] vel_mem   [MAX_WIDTH];

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [GW_W-1:0]  col_plus;
  logic [GH_W-1:0]  row_plus;

  logic signed [SAMPLE_BITS-1:0] u_r, v_r, f_r;
  logic [COL_W-1:0] pcol_r;
  logic [ROW_W-1:0] prow_r;
  logic             plast_r;
  logic             is_last;

  logic [FADDR_W-1:0] f_raddr, f_waddr;
  logic               f_re;
  logic [SAMPLE_BITS-1:0]   frd_r;
  logic [2*SAMPLE_BITS-1:0] vrd_r;

  logic signed [SAMPLE_BITS-1:0] left_r, mid_r, right_r;
  logic signed [SAMPLE_BITS:0]   dx_diff, dy_diff;
  logic signed [SAMPLE_BITS-1:0] dx, dy, vu, vv, up;
  logic signed [2*SAMPLE_BITS-1:0] prod_x_r, prod_y_r;
  logic signed [2*SAMPLE_BITS:0]   grad_sum;
  logic signed [20:0]              s_r;
  logic signed [37:0]              dt_prod;
  logic signed [21:0]              p_r;
  logic signed [22:0]              res;
  logic signed [SAMPLE_BITS-1:0]   res_sat;

  logic                   out_valid_r;
  logic [SAMPLE_BITS-1:0] out_val_r;
  logic [ROW_W-1:0]       out_row_r;
  logic [COL_W-1:0]       out_col_r;
  logic                   out_last_r;

  // position of the next point and what it means
  assign col_plus = {1'b0, col_r} + GW_W'(1);
  assign row_plus = {1'b0, row_r} + GH_W'(1);
  assign is_last  = ({1'b0, row_r} == geom.height - GH_W'(1)) &&
                    ({1'b0, col_r} == geom.width - GW_W'(2));

  assign stat.interior = (row_r >= ROW_W'(2)) && (col_r != '0) &&
                         ({1'b0, col_r} <= geom.width - GW_W'(2));
  assign stat.out_free = !out_valid_r || out_tready;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cmd.take) begin
      if (col_plus >= geom.width) begin
        col_nxt = '0;
        row_nxt = (row_plus >= geom.height) ? '0 : row_plus[ROW_W-1:0];
      end else begin
        col_nxt = col_plus[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (restart) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      u_r     <= in_tdata[15:0];
      v_r     <= in_tdata[31:16];
      f_r     <= in_tdata[47:32];
      pcol_r  <= col_r;
      prow_r  <= row_r;
      plast_r <= is_last;
    end
  end

  // center row sits in the bank of the opposite parity, the row above in the same one
  always_comb begin
    f_re    = cmd.rd_left || cmd.rd_mid || cmd.rd_right || cmd.rd_up;
    f_raddr = {~prow_r[0], pcol_r};
    if (cmd.rd_left) begin
      f_raddr = {~prow_r[0], pcol_r - COL_W'(1)};
    end else if (cmd.rd_right) begin
      f_raddr = {~prow_r[0], pcol_r + COL_W'(1)};
    end else if (cmd.rd_up) begin
      f_raddr = {prow_r[0], pcol_r};
    end
  end
  assign f_waddr = {prow_r[0], pcol_r};

  always_ff @(posedge clk) begin
    if (cmd.write_store) begin
      field_mem[f_waddr] <= f_r;
    end
    if (f_re) begin
      frd_r <= field_mem[f_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write_store) begin
      vel_mem[pcol_r] <= {v_r, u_r};
    end
    if (cmd.rd_left) begin
      vrd_r <= vel_mem[pcol_r];
    end
  end

  // stencil arithmetic, one product per step
  assign vu      = vrd_r[SAMPLE_BITS-1:0];
  assign vv      = vrd_r[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign up      = frd_r;
  assign dx_diff = {right_r[SAMPLE_BITS-1], right_r} - {left_r[SAMPLE_BITS-1], left_r};
  assign dy_diff = {f_r[SAMPLE_BITS-1], f_r} - {up[SAMPLE_BITS-1], up};
  assign dx      = dx_diff[SAMPLE_BITS:1];
  assign dy      = dy_diff[SAMPLE_BITS:1];
  assign grad_sum = {prod_x_r[2*SAMPLE_BITS-1], prod_x_r} +
                    {prod_y_r[2*SAMPLE_BITS-1], prod_y_r};
  assign dt_prod = 38'($signed({1'b0, geom.dt})) * 38'(s_r);
  assign res     = {{7{mid_r[SAMPLE_BITS-1]}}, mid_r} - {p_r[21], p_r};

  always_comb begin
    if (res[22:15] == 8'h00 || res[22:15] == 8'hff) begin
      res_sat = res[SAMPLE_BITS-1:0];
    end else if (res[22]) begin
      res_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      res_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_left) begin
      left_r <= frd_r;
    end
    if (cmd.cap_mid) begin
      mid_r <= frd_r;
    end
    if (cmd.cap_right) begin
      right_r <= frd_r;
    end
    if (cmd.mul_x) begin
      prod_x_r <= (2*SAMPLE_BITS)'(vu) * (2*SAMPLE_BITS)'(dx);
    end
    if (cmd.mul_y) begin
      prod_y_r <= (2*SAMPLE_BITS)'(vv) * (2*SAMPLE_BITS)'(dy);
    end
    if (cmd.sum) begin
      s_r <= grad_sum[2*SAMPLE_BITS:12];
    end
    if (cmd.scale) begin
      p_r <= dt_prod[37:16];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_val_r  <= res_sat;
      out_row_r  <= prow_r - ROW_W'(1);
      out_col_r  <= pcol_r;
      out_last_r <= plast_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_col_r, out_row_r, out_val_r};
  assign out_tlast  = out_last_r;

endmodule

// ===== rtl/core/advection_stencil_stream.sv =====
// 2-d advection stencil over a raster-order stream of grid points
//
// in_*  : one word per grid point, raster order, column 0 first.
// out_* : one word per interior point (row 1..H-2, col 1..W-2), given when the
//         point below it arrives; out_tlast marks the last interior point.
// cfg_* : register writes (0 grid_width, 1 grid_height, 2 time_step), always
//         ready; a geometry write restarts the frame at row 0, column 0.
// A boundary point is only written to the line stores. An interior point steps
// through the four reads of the field line store, which has one read port, then
// the gradient products, their sum, the dt product and the saturating subtract,
// and its result is loaded into the output register that drives out_tvalid.
// The output register lets the next point be accepted while a result waits;
// if the receiver stalls, an interior point holds in its last step until the
// register frees, and in_tready stays low meanwhile.
// Reset clears the counters, the control and the output valid flag and loads
// width 256, height 256, time step 66; line stores are not cleared.
module advection_stencil_stream import asc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_W-1:0]       in_tdata,    // u_sample, v_sample, field_sample
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_W-1:0]      out_tdata,   // new_value, out_row, out_col, zero pad
  output logic                  out_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [GW_W-1:0] grid_width_r;
  logic [GH_W-1:0] grid_height_r;
  logic [DT_W-1:0] time_step_r;
  logic            cfg_we;
  logic            restart;
  geom_t           geom;
  cmd_t            cmd;
  stat_t           stat;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= GW_RESET;
      grid_height_r <= GH_RESET;
      time_step_r   <= DT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRID_WIDTH:  grid_width_r  <= cfg_data[GW_W-1:0];
        REG_GRID_HEIGHT: grid_height_r <= cfg_data[GH_W-1:0];
        REG_TIME_STEP:   time_step_r   <= cfg_data[DT_W-1:0];
        default: ;
      endcase
    end
  end

  assign restart = cfg_we &&
                   (cfg_index == REG_GRID_WIDTH || cfg_index == REG_GRID_HEIGHT);

  // clamp geometry to the supported range
  always_comb begin
    if (grid_width_r < GW_MIN) begin
      geom.width = GW_MIN;
    end else if (grid_width_r > GW_MAX) begin
      geom.width = GW_MAX;
    end else begin
      geom.width = grid_width_r;
    end
    if (grid_height_r < GH_MIN) begin
      geom.height = GH_MIN;
    end else if (grid_height_r > GH_MAX) begin
      geom.height = GH_MAX;
    end else begin
      geom.height = grid_height_r;
    end
    geom.dt = time_step_r;
  end

  asc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  asc_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .geom       (geom),
    .restart    (restart),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
